FILE: rtl/prt_pkg.sv
// Package for the prefix route table: sizes, mode and status codes, helpers.
// No dependencies.
package prt_pkg;

	localparam int SLOTS_DEF   = 64;
	localparam int TUNNELS_DEF = 16;

	typedef enum logic [2:0] {
		MODE_UPDATE    = 3'd0,
		MODE_LOOKUP_T  = 3'd1,
		MODE_LOOKUP_A  = 3'd2,
		MODE_REMOVE    = 3'd3,
		MODE_CLEAR_T   = 3'd4,
		MODE_CLEAR_A   = 3'd5,
		MODE_COUNT_T   = 3'd6,
		MODE_COUNT_A   = 3'd7
	} mode_t;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_TUN  = 2'd2;

	localparam logic [7:0] REG_TUNNELS = 8'd0;

	// Mask for a prefix length, most significant bit first.
	function automatic logic [31:0] prefix_mask(input logic [5:0] p);
		logic [31:0] m;
		if (p == 6'd0) begin
			m = 32'h0;
		end else if (p >= 6'd32) begin
			m = 32'hFFFF_FFFF;
		end else begin
			m = 32'hFFFF_FFFF << (6'd32 - p);
		end
		return m;
	endfunction

	// Commands from controller to datapath.
	typedef struct packed {
		logic start;     // latch request, reset scan
		logic scan;      // process slot at scan index
		logic commit;    // apply write-back and form result
	} cmd_t;

	// Status from datapath to controller.
	typedef struct packed {
		logic scan_last; // read data stage holds the last slot
	} sts_t;

endpackage

FILE: rtl/prt_if.sv
// Valid/ready channel interfaces for the route table.
// Depends on nothing.
interface prt_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  mode;
	logic [3:0]  tunnel;
	logic [31:0] address;
	logic [5:0]  prefix_len;
	logic [31:0] nexthop;
	logic [31:0] now;
	modport source (output valid, mode, tunnel, address, prefix_len, nexthop, now,
		input ready);
	modport sink (input valid, mode, tunnel, address, prefix_len, nexthop, now,
		output ready);
endinterface

interface prt_rsp_if;
	logic        valid;
	logic        ready;
	logic        found;
	logic [1:0]  status;
	logic        changed;
	logic [3:0]  hit_tunnel;
	logic [31:0] hit_address;
	logic [5:0]  hit_prefix;
	logic [31:0] hit_nexthop;
	logic [31:0] hit_stamp;
	logic [6:0]  entry_count;
	modport source (output valid, found, status, changed, hit_tunnel, hit_address,
		hit_prefix, hit_nexthop, hit_stamp, entry_count, input ready);
	modport sink (input valid, found, status, changed, hit_tunnel, hit_address,
		hit_prefix, hit_nexthop, hit_stamp, entry_count, output ready);
endinterface

FILE: rtl/prt_ctrl.sv
// Controller for the route table: sequences request, slot scan and commit.
// Depends on prt_pkg.
module prt_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic          out_busy,
	input  prt_pkg::sts_t sts,
	output prt_pkg::cmd_t cmd
);
	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_COMMIT} state_t;
	state_t state_q;

	// Ready only when idle; commit waits for the result register to be free.
	assign in_ready   = (state_q == S_IDLE);
	assign cmd.start  = in_valid && (state_q == S_IDLE);
	assign cmd.scan   = (state_q == S_SCAN);
	assign cmd.commit = (state_q == S_COMMIT) && !out_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (sts.scan_last) state_q <= S_COMMIT;
				end
				S_COMMIT: begin
					if (!out_busy) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

FILE: rtl/prt_dp.sv
// Datapath for the route table: slot memory, serial scan, best-match and commit.
// Depends on prt_pkg.
module prt_dp #(
	parameter int SLOTS   = prt_pkg::SLOTS_DEF,
	parameter int TUNNELS = prt_pkg::TUNNELS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  prt_pkg::cmd_t cmd,
	output prt_pkg::sts_t sts,
	input  logic [4:0]    tunnels_cfg,
	input  logic [2:0]    in_mode,
	input  logic [3:0]    in_tunnel,
	input  logic [31:0]   in_address,
	input  logic [5:0]    in_prefix_len,
	input  logic [31:0]   in_nexthop,
	input  logic [31:0]   in_now,
	output logic          res_valid,
	input  logic          res_ready,
	output logic          res_found,
	output logic [1:0]    res_status,
	output logic          res_changed,
	output logic [3:0]    res_hit_tunnel,
	output logic [31:0]   res_hit_address,
	output logic [5:0]    res_hit_prefix,
	output logic [31:0]   res_hit_nexthop,
	output logic [31:0]   res_hit_stamp,
	output logic [6:0]    res_entry_count
);
	localparam int IW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);
	localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

	// Slot payload memory: one read port (scan/commit), one write port.
	logic [3:0]  mem_tun  [SLOTS];
	logic [31:0] mem_addr [SLOTS];
	logic [5:0]  mem_pfx  [SLOTS];
	logic [31:0] mem_nh   [SLOTS];
	logic [31:0] mem_stamp[SLOTS];
	logic [31:0] mem_ord  [SLOTS];
	logic [SLOTS-1:0] valid_q;

	// Latched request.
	prt_pkg::mode_t mode_q;
	logic [3:0]  tun_q;
	logic [31:0] addr_q;
	logic [5:0]  plen_q;
	logic [31:0] nh_q;
	logic [31:0] now_q;
	logic [4:0]  nt_q;
	logic [31:0] icnt_q;

	// Scan state: read address, read data stage, per-slot outcomes.
	logic [IW-1:0] ridx_q;
	logic          rd_v_s1;
	logic [IW-1:0] rd_idx_s1;
	logic [3:0]    rd_tun_s1;
	logic [31:0]   rd_addr_s1;
	logic [5:0]    rd_pfx_s1;
	logic [31:0]   rd_ord_s1;

	logic          key_hit_q;
	logic [IW-1:0] key_idx_q;
	logic          key_chg_q;
	logic          free_hit_q;
	logic [IW-1:0] free_idx_q;
	logic          best_hit_q;
	logic [IW-1:0] best_idx_q;
	logic [5:0]    best_p_q;
	logic [3:0]    best_t_q;
	logic [31:0]   best_age_q;
	logic [CW-1:0] cnt_q;

	// Commit phase two: result formed from the registered readout.
	logic          fin_q;

	logic [3:0]  rd_tun;
	logic [31:0] rd_addr, rd_nh, rd_stamp;
	logic [5:0]  rd_pfx;
	logic [4:0]  nt_eff;

	// Saturate the tunnel count into one through TUNNELS.
	always_comb begin
		if (tunnels_cfg == 5'd0) nt_eff = 5'd1;
		else if (32'(tunnels_cfg) > TUNNELS) nt_eff = 5'(TUNNELS);
		else nt_eff = tunnels_cfg;
	end

	assign sts.scan_last = rd_v_s1 && (rd_idx_s1 == LAST);

	// Per-slot evaluation of the registered slot data.
	logic        sel_ok, in_all, in_one, lmatch, better;
	logic [31:0] age, m;
	always_comb begin
		in_one = (rd_tun_s1 == tun_q);
		in_all = ({1'b0, rd_tun_s1} < nt_q);
		sel_ok = (mode_q == prt_pkg::MODE_LOOKUP_T) ? in_one : in_all;
		m      = prt_pkg::prefix_mask(rd_pfx_s1);
		age    = icnt_q - rd_ord_s1;
		lmatch = valid_q[rd_idx_s1] && sel_ok && (rd_pfx_s1 != 6'd0) &&
			((rd_addr_s1 & m) == (addr_q & m));
		better = !best_hit_q || (rd_pfx_s1 > best_p_q) ||
			((rd_pfx_s1 == best_p_q) && ((rd_tun_s1 < best_t_q) ||
			((rd_tun_s1 == best_t_q) && (age < best_age_q))));
	end

	logic tun_bad, do_write, do_ins, do_upd, is_lookup;
	assign tun_bad = (mode_q != prt_pkg::MODE_LOOKUP_A) && (mode_q != prt_pkg::MODE_CLEAR_A)
		&& (mode_q != prt_pkg::MODE_COUNT_A) && ({1'b0, tun_q} >= nt_q);
	assign do_upd = cmd.commit && !tun_bad && (mode_q == prt_pkg::MODE_UPDATE) && key_hit_q;
	assign do_ins = cmd.commit && !tun_bad && (mode_q == prt_pkg::MODE_UPDATE) &&
		!key_hit_q && free_hit_q;
	assign do_write = do_upd || do_ins;
	assign is_lookup = (mode_q == prt_pkg::MODE_LOOKUP_T) || (mode_q == prt_pkg::MODE_LOOKUP_A);

	// Memory write and registered read port.
	logic [IW-1:0] raddr;
	assign raddr = cmd.commit ? (is_lookup ? best_idx_q : key_idx_q) : ridx_q;
	always_ff @(posedge clk) begin
		if (do_ins) begin
			mem_tun[free_idx_q]  <= tun_q;
			mem_addr[free_idx_q] <= addr_q;
			mem_pfx[free_idx_q]  <= plen_q;
			mem_ord[free_idx_q]  <= icnt_q;
		end
		if (do_write) begin
			mem_nh[do_ins ? free_idx_q : key_idx_q]    <= nh_q;
			mem_stamp[do_ins ? free_idx_q : key_idx_q] <= now_q;
		end
		rd_tun     <= mem_tun[raddr];
		rd_addr    <= mem_addr[raddr];
		rd_pfx     <= mem_pfx[raddr];
		rd_nh      <= mem_nh[raddr];
		rd_stamp   <= mem_stamp[raddr];
		rd_ord_s1  <= mem_ord[raddr];
	end
	assign rd_tun_s1  = rd_tun;
	assign rd_addr_s1 = rd_addr;
	assign rd_pfx_s1  = rd_pfx;

	// Request latch, scan and commit.
	logic nh_diff;
	assign nh_diff = (rd_nh != nh_q);
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			mode_q <= prt_pkg::mode_t'(in_mode);
			tun_q  <= in_tunnel;
			addr_q <= in_address;
			plen_q <= (in_prefix_len > 6'd32) ? 6'd32 : in_prefix_len;
			nh_q   <= in_nexthop;
			now_q  <= in_now;
			nt_q   <= nt_eff;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			icnt_q     <= '0;
			ridx_q     <= '0;
			rd_v_s1    <= 1'b0;
			rd_idx_s1  <= '0;
			key_hit_q  <= 1'b0;
			key_idx_q  <= '0;
			key_chg_q  <= 1'b0;
			free_hit_q <= 1'b0;
			free_idx_q <= '0;
			best_hit_q <= 1'b0;
			best_idx_q <= '0;
			best_p_q   <= '0;
			best_t_q   <= '0;
			best_age_q <= '0;
			cnt_q      <= '0;
			fin_q      <= 1'b0;
			res_valid  <= 1'b0;
			res_found  <= 1'b0;
			res_status <= prt_pkg::ST_OK;
			res_changed <= 1'b0;
			res_entry_count <= '0;
			res_hit_tunnel <= '0;
			res_hit_address <= '0;
			res_hit_prefix <= '0;
			res_hit_nexthop <= '0;
			res_hit_stamp <= '0;
		end else begin
			if (res_valid && res_ready) res_valid <= 1'b0;
			if (cmd.start) begin
				ridx_q     <= '0;
				rd_v_s1    <= 1'b0;
				key_hit_q  <= 1'b0;
				free_hit_q <= 1'b0;
				best_hit_q <= 1'b0;
				cnt_q      <= '0;
			end
			// Scan issues one read per cycle, evaluating the previous one.
			if (cmd.scan) begin
				if (!(rd_v_s1 && rd_idx_s1 == LAST)) begin
					rd_v_s1   <= 1'b1;
					rd_idx_s1 <= ridx_q;
					if (ridx_q != LAST) ridx_q <= ridx_q + 1'b1;
				end else begin
					rd_v_s1 <= 1'b0;
				end
				if (rd_v_s1) begin
					if (!key_hit_q && valid_q[rd_idx_s1] && in_one &&
						rd_addr_s1 == addr_q && rd_pfx_s1 == plen_q) begin
						key_hit_q <= 1'b1;
						key_idx_q <= rd_idx_s1;
						key_chg_q <= nh_diff;
					end
					if (!free_hit_q && !valid_q[rd_idx_s1]) begin
						free_hit_q <= 1'b1;
						free_idx_q <= rd_idx_s1;
					end
					if (lmatch && better) begin
						best_hit_q <= 1'b1;
						best_idx_q <= rd_idx_s1;
						best_p_q   <= rd_pfx_s1;
						best_t_q   <= rd_tun_s1;
						best_age_q <= age;
					end
					if (valid_q[rd_idx_s1] && ((mode_q == prt_pkg::MODE_COUNT_T) ? in_one
						: in_all)) cnt_q <= cnt_q + 1'b1;
					if (valid_q[rd_idx_s1] && !tun_bad &&
						(((mode_q == prt_pkg::MODE_CLEAR_T) && in_one) ||
						((mode_q == prt_pkg::MODE_CLEAR_A) && in_all)))
						valid_q[rd_idx_s1] <= 1'b0;
				end
			end
			// Commit: write back and read the hit slot for the result.
			fin_q <= cmd.commit;
			if (cmd.commit) begin
				if (do_ins) begin
					valid_q[free_idx_q] <= 1'b1;
					icnt_q <= icnt_q + 1'b1;
				end
				if (mode_q == prt_pkg::MODE_REMOVE && !tun_bad && key_hit_q)
					valid_q[key_idx_q] <= 1'b0;
			end
			if (fin_q) begin
				logic hit;
				logic from_req;
				hit = 1'b0;
				from_req = 1'b0;
				res_valid       <= 1'b1;
				res_found       <= 1'b0;
				res_status      <= prt_pkg::ST_OK;
				res_changed     <= 1'b0;
				res_entry_count <= '0;
				if (tun_bad) begin
					res_status <= prt_pkg::ST_TUN;
				end else begin
					unique case (mode_q)
						prt_pkg::MODE_UPDATE: begin
							// The refreshed or inserted entry equals the request.
							if (key_hit_q) begin
								from_req = 1'b1;
								res_found <= 1'b1;
								res_changed <= key_chg_q;
							end else if (free_hit_q) begin
								from_req = 1'b1;
								res_changed <= 1'b1;
							end else begin
								res_status <= prt_pkg::ST_FULL;
							end
						end
						prt_pkg::MODE_LOOKUP_T, prt_pkg::MODE_LOOKUP_A: begin
							hit = best_hit_q;
							res_found <= best_hit_q;
						end
						prt_pkg::MODE_REMOVE: begin
							hit = key_hit_q;
							res_found <= key_hit_q;
						end
						prt_pkg::MODE_COUNT_T, prt_pkg::MODE_COUNT_A:
							res_entry_count <= 7'(cnt_q);
						default: ;
					endcase
				end
				res_hit_tunnel  <= from_req ? tun_q  : (hit ? rd_tun   : '0);
				res_hit_address <= from_req ? addr_q : (hit ? rd_addr  : '0);
				res_hit_prefix  <= from_req ? plen_q : (hit ? rd_pfx   : '0);
				res_hit_nexthop <= from_req ? nh_q   : (hit ? rd_nh    : '0);
				res_hit_stamp   <= from_req ? now_q  : (hit ? rd_stamp : '0);
			end
		end
	end
endmodule

FILE: rtl/prefix_route_table.sv
// Top level of the prefix route table: APB register, controller and datapath.
// Depends on prt_pkg, prt_if, prt_ctrl and prt_dp.
//
// Usage: requests arrive as transfers on req (mode, tunnel, address,
// prefix_len, nexthop, now); one result per request leaves on rsp.
// Each request walks every slot through a single memory read port, one slot
// per cycle; a commit step then writes back and reads the hit slot, and the
// result is registered. A new request is taken once the previous one has
// committed. The result register holds a finished transfer while the
// receiver stalls; the next request may scan meanwhile and waits only at
// commit. Register tunnels_in_use sits at byte address 0 and must be written
// over APB only while idle; the block itself does not enforce this. Reset
// clears all slot valid bits, the insertion counter and the control state
// at once; tunnels_in_use resets to 16. Slot payloads are undefined until
// written and are ignored while invalid.
module prefix_route_table #(
	parameter int SLOTS   = prt_pkg::SLOTS_DEF,
	parameter int TUNNELS = prt_pkg::TUNNELS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	prt_req_if.sink     req,
	prt_rsp_if.source   rsp
);
	logic [4:0] tunnels_q;
	prt_pkg::cmd_t cmd;
	prt_pkg::sts_t sts;

	// Configuration register.
	assign pready = 1'b1;
	assign prdata = (paddr == prt_pkg::REG_TUNNELS[1:0]) ? {27'd0, tunnels_q} : 32'd0;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tunnels_q <= 5'd16;
		end else if (psel && penable && pwrite && paddr == prt_pkg::REG_TUNNELS[1:0]) begin
			tunnels_q <= pwdata[4:0];
		end
	end

	prt_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(req.valid), .in_ready(req.ready),
		.out_busy(rsp.valid && !rsp.ready), .sts(sts), .cmd(cmd)
	);

	prt_dp #(.SLOTS(SLOTS), .TUNNELS(TUNNELS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .tunnels_cfg(tunnels_q),
		.in_mode(req.mode), .in_tunnel(req.tunnel), .in_address(req.address),
		.in_prefix_len(req.prefix_len), .in_nexthop(req.nexthop), .in_now(req.now),
		.res_valid(rsp.valid), .res_ready(rsp.ready), .res_found(rsp.found),
		.res_status(rsp.status), .res_changed(rsp.changed),
		.res_hit_tunnel(rsp.hit_tunnel), .res_hit_address(rsp.hit_address),
		.res_hit_prefix(rsp.hit_prefix), .res_hit_nexthop(rsp.hit_nexthop),
		.res_hit_stamp(rsp.hit_stamp), .res_entry_count(rsp.entry_count)
	);
endmodule

FILE: rtl/prt_check.sv
// Port-level checker for the prefix route table, bound to the top level.
// Depends on prt_pkg.
module prt_check (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [1:0]  rsp_status,
	input logic        rsp_found,
	input logic [6:0]  rsp_entry_count
);
	// A stalled result holds its valid.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid) else $error("result dropped");
	// Accepting a request drops ready the next cycle.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready) else $error("ready while busy");
	// Status never carries the unused code.
	a_stat: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_status != 2'd3) else $error("bad status");
	// Out-of-range tunnel answers carry no hit and a zero entry count.
	a_tun: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == prt_pkg::ST_TUN |-> !rsp_found && rsp_entry_count == 7'd0)
		else $error("hit on bad tunnel");
endmodule

bind prefix_route_table prt_check u_check (
	.clk(clk), .arst_n(arst_n), .req_valid(req.valid), .req_ready(req.ready),
	.rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_status(rsp.status),
	.rsp_found(rsp.found), .rsp_entry_count(rsp.entry_count)
);

FILE: tb/prefix_route_table_tb.sv
// Testbench for prefix_route_table: drives route requests and APB register writes,
// predicts every result with a behavioral route table and compares field by field.
// Depends on prt_pkg, prt_if and the prefix_route_table RTL.
module prefix_route_table_tb;

	localparam int NSLOT = 64;

	typedef struct packed {
		logic [2:0]  mode;
		logic [3:0]  tunnel;
		logic [31:0] address;
		logic [5:0]  prefix_len;
		logic [31:0] nexthop;
		logic [31:0] now;
	} route_req_t;

	typedef struct packed {
		logic        found;
		logic [1:0]  status;
		logic        changed;
		logic [3:0]  hit_tunnel;
		logic [31:0] hit_address;
		logic [5:0]  hit_prefix;
		logic [31:0] hit_nexthop;
		logic [31:0] hit_stamp;
		logic [6:0]  entry_count;
	} route_rsp_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [1:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	prt_req_if req ();
	prt_rsp_if rsp ();

	prefix_route_table i_dut (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.req(req.sink), .rsp(rsp.source)
	);

	// Shadow route table.
	logic        tbl_valid [NSLOT];
	logic [3:0]  tbl_tunnel [NSLOT];
	logic [31:0] tbl_address [NSLOT];
	logic [5:0]  tbl_prefix [NSLOT];
	logic [31:0] tbl_nexthop [NSLOT];
	logic [31:0] tbl_stamp [NSLOT];
	logic [31:0] tbl_order [NSLOT];
	logic [31:0] insert_seq;
	logic [4:0]  tunnel_limit;

	route_req_t  pending_reqs[$];
	route_rsp_t  expected_rsps[$];
	int          error_count;
	bit          calm;
	bit          hold_reqs;
	bit          req_fire;
	int          req_gap;
	int          rsp_stall;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic int active_tunnels();
		if (tunnel_limit == 5'd0) begin
			return 1;
		end
		if (tunnel_limit > 5'd16) begin
			return 16;
		end
		return int'(tunnel_limit);
	endfunction

	function automatic logic [31:0] route_mask(input logic [5:0] p);
		if (p == 6'd0) begin
			return 32'h0;
		end
		return 32'hFFFF_FFFF << (32 - int'(p));
	endfunction

	function automatic void fill_hit(inout route_rsp_t r, input int s);
		r.hit_tunnel  = tbl_tunnel[s];
		r.hit_address = tbl_address[s];
		r.hit_prefix  = tbl_prefix[s];
		r.hit_nexthop = tbl_nexthop[s];
		r.hit_stamp   = tbl_stamp[s];
	endfunction

	function automatic int find_route(input logic [3:0] t, input logic [31:0] a,
		input logic [5:0] p);
		for (int s = 0; s < NSLOT; s++) begin
			if (tbl_valid[s] && tbl_tunnel[s] == t && tbl_address[s] == a &&
				tbl_prefix[s] == p) begin
				return s;
			end
		end
		return -1;
	endfunction

	// Longest prefix over tunnels lo..hi-1; lower tunnel, then newest entry, wins ties.
	function automatic int longest_match(input int lo, input int hi, input logic [31:0] a);
		int best;
		logic [5:0] bp;
		int bt;
		logic [31:0] bage;
		logic [31:0] age;
		logic [31:0] m;
		best = -1;
		bp = 0;
		bt = 0;
		bage = 0;
		for (int s = 0; s < NSLOT; s++) begin
			if (!tbl_valid[s] || tbl_tunnel[s] < lo || tbl_tunnel[s] >= hi ||
				tbl_prefix[s] == 6'd0) begin
				continue;
			end
			m = route_mask(tbl_prefix[s]);
			if ((tbl_address[s] & m) != (a & m)) begin
				continue;
			end
			age = insert_seq - tbl_order[s];
			if (best < 0 || tbl_prefix[s] > bp || (tbl_prefix[s] == bp &&
				(tbl_tunnel[s] < bt || (tbl_tunnel[s] == bt && age < bage)))) begin
				best = s;
				bp = tbl_prefix[s];
				bt = tbl_tunnel[s];
				bage = age;
			end
		end
		return best;
	endfunction

	// Apply one request to the shadow table and return its result.
	function automatic route_rsp_t apply_route_op(input route_req_t q);
		route_rsp_t r;
		int nt;
		int s;
		logic [5:0] p;
		logic [6:0] cnt;
		r = '0;
		nt = active_tunnels();
		p = (q.prefix_len > 6'd32) ? 6'd32 : q.prefix_len;
		cnt = 0;
		if (q.mode != prt_pkg::MODE_LOOKUP_A && q.mode != prt_pkg::MODE_CLEAR_A &&
			q.mode != prt_pkg::MODE_COUNT_A && int'(q.tunnel) >= nt) begin
			r.status = prt_pkg::ST_TUN;
			return r;
		end
		case (prt_pkg::mode_t'(q.mode))
			prt_pkg::MODE_UPDATE: begin
				s = find_route(q.tunnel, q.address, p);
				if (s >= 0) begin
					if (tbl_nexthop[s] != q.nexthop) begin
						tbl_nexthop[s] = q.nexthop;
						r.changed = 1'b1;
					end
					tbl_stamp[s] = q.now;
					r.found = 1'b1;
					fill_hit(r, s);
				end else begin
					s = 0;
					while (s < NSLOT && tbl_valid[s]) begin
						s++;
					end
					if (s >= NSLOT) begin
						r.status = prt_pkg::ST_FULL;
					end else begin
						tbl_valid[s] = 1'b1;
						tbl_tunnel[s] = q.tunnel;
						tbl_address[s] = q.address;
						tbl_prefix[s] = p;
						tbl_nexthop[s] = q.nexthop;
						tbl_stamp[s] = q.now;
						tbl_order[s] = insert_seq;
						insert_seq = insert_seq + 1;
						r.changed = 1'b1;
						fill_hit(r, s);
					end
				end
			end
			prt_pkg::MODE_LOOKUP_T, prt_pkg::MODE_LOOKUP_A: begin
				s = (q.mode == prt_pkg::MODE_LOOKUP_T) ?
					longest_match(int'(q.tunnel), int'(q.tunnel) + 1, q.address) :
					longest_match(0, nt, q.address);
				if (s >= 0) begin
					r.found = 1'b1;
					fill_hit(r, s);
				end
			end
			prt_pkg::MODE_REMOVE: begin
				s = find_route(q.tunnel, q.address, p);
				if (s >= 0) begin
					r.found = 1'b1;
					fill_hit(r, s);
					tbl_valid[s] = 1'b0;
				end
			end
			prt_pkg::MODE_CLEAR_T, prt_pkg::MODE_CLEAR_A: begin
				for (int i = 0; i < NSLOT; i++) begin
					if (tbl_valid[i] && (q.mode == prt_pkg::MODE_CLEAR_T ?
						tbl_tunnel[i] == q.tunnel : int'(tbl_tunnel[i]) < nt)) begin
						tbl_valid[i] = 1'b0;
					end
				end
			end
			default: begin
				for (int i = 0; i < NSLOT; i++) begin
					if (tbl_valid[i] && (q.mode == prt_pkg::MODE_COUNT_T ?
						tbl_tunnel[i] == q.tunnel : int'(tbl_tunnel[i]) < nt)) begin
						cnt++;
					end
				end
				r.entry_count = cnt;
			end
		endcase
		return r;
	endfunction

	function automatic route_req_t make_req(input prt_pkg::mode_t m, input logic [3:0] t,
		input logic [31:0] a, input logic [5:0] p, input logic [31:0] nh,
		input logic [31:0] n);
		route_req_t q;
		q.mode = m;
		q.tunnel = t;
		q.address = a;
		q.prefix_len = p;
		q.nexthop = nh;
		q.now = n;
		return q;
	endfunction

	// Random request, mostly updates and lookups, addresses mostly under 10.0.0.0/14 or 255.0.0.0/14.
	function automatic route_req_t random_req(input int tmax);
		route_req_t q;
		int pick;
		q.tunnel = 4'($urandom_range(tmax, 0));
		q.address = ($urandom_range(3, 0) == 0) ? $urandom() :
			{$urandom_range(3, 0) == 0 ? 8'd255 : 8'd10, 8'($urandom_range(3, 0)),
			16'($urandom())};
		q.prefix_len = ($urandom_range(9, 0) == 0) ? 6'($urandom_range(63, 33)) :
			(($urandom_range(3, 0) == 0) ? 6'($urandom_range(32, 0)) :
			6'(8 * $urandom_range(4, 0)));
		q.nexthop = ($urandom_range(1, 0) == 0) ? 32'($urandom_range(3, 0)) : $urandom();
		q.now = $urandom();
		pick = $urandom_range(99, 0);
		if (pick < 40) begin
			q.mode = prt_pkg::MODE_UPDATE;
		end else if (pick < 60) begin
			q.mode = prt_pkg::MODE_LOOKUP_T;
		end else if (pick < 78) begin
			q.mode = prt_pkg::MODE_LOOKUP_A;
		end else if (pick < 88) begin
			q.mode = prt_pkg::MODE_REMOVE;
		end else if (pick < 90) begin
			q.mode = prt_pkg::MODE_CLEAR_T;
		end else if (pick < 91) begin
			q.mode = prt_pkg::MODE_CLEAR_A;
		end else if (pick < 96) begin
			q.mode = prt_pkg::MODE_COUNT_T;
		end else begin
			q.mode = prt_pkg::MODE_COUNT_A;
		end
		return q;
	endfunction

	// Remember a request transfer at the rising edge for the driver.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_fire <= 1'b0;
		end else begin
			req_fire <= req.valid && req.ready;
		end
	end

	// Request driver: one transfer per queued item, with random gaps.
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			req_gap <= 0;
		end else if (req_fire) begin
			if (pending_reqs.size() > 0 && !hold_reqs && (calm || $urandom_range(3, 0) != 0))
				begin
				{req.mode, req.tunnel, req.address, req.prefix_len, req.nexthop, req.now}
					<= pending_reqs.pop_front();
			end else begin
				req.valid <= 1'b0;
				req_gap <= calm ? 0 : $urandom_range(7, 1);
			end
		end else if (!req.valid) begin
			if (req_gap > 0) begin
				req_gap <= req_gap - 1;
			end else if (pending_reqs.size() > 0 && !hold_reqs) begin
				req.valid <= 1'b1;
				{req.mode, req.tunnel, req.address, req.prefix_len, req.nexthop, req.now}
					<= pending_reqs.pop_front();
			end
		end
	end

	// Response ready with random stall bursts.
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			rsp_stall <= 0;
		end else if (rsp_stall > 0) begin
			rsp_stall <= rsp_stall - 1;
			rsp.ready <= (rsp_stall == 1);
		end else if (!calm && $urandom_range(9, 0) == 0) begin
			rsp.ready <= 1'b0;
			rsp_stall <= $urandom_range(7, 1);
		end else begin
			rsp.ready <= 1'b1;
		end
	end

	// Monitor: predict on request transfer, compare on response transfer.
	always @(posedge clk) begin
		route_rsp_t got;
		route_rsp_t want;
		if (arst_n) begin
			if (req.valid && req.ready) begin
				expected_rsps.push_back(apply_route_op({req.mode, req.tunnel, req.address,
					req.prefix_len, req.nexthop, req.now}));
			end
			if (rsp.valid && rsp.ready) begin
				got = {rsp.found, rsp.status, rsp.changed, rsp.hit_tunnel, rsp.hit_address,
					rsp.hit_prefix, rsp.hit_nexthop, rsp.hit_stamp, rsp.entry_count};
				if (expected_rsps.size() == 0) begin
					$display("%0t: unexpected result %h", $time, got);
					error_count++;
				end else begin
					want = expected_rsps.pop_front();
					if (got.found !== want.found || got.status !== want.status ||
						got.changed !== want.changed || got.hit_tunnel !== want.hit_tunnel ||
						got.hit_address !== want.hit_address ||
						got.hit_prefix !== want.hit_prefix ||
						got.hit_nexthop !== want.hit_nexthop ||
						got.hit_stamp !== want.hit_stamp ||
						got.entry_count !== want.entry_count) begin
						$display("%0t: mismatch expected %h actual %h", $time, want, got);
						error_count++;
					end
				end
			end
		end
	end

	task automatic wait_drained();
		while (pending_reqs.size() > 0 || req.valid || expected_rsps.size() > 0) begin
			@(posedge clk);
		end
		repeat (80) @(posedge clk);
	endtask

	task automatic write_tunnels(input logic [4:0] v);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= prt_pkg::REG_TUNNELS[1:0];
		pwdata <= {27'd0, v};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		tunnel_limit = v;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic run_random(input int n, input int tmax);
		for (int i = 0; i < n; i++) begin
			pending_reqs.push_back(random_req(tmax));
		end
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = 2'd0;
		pwdata = 32'd0;
		req.valid = 1'b0;
		req.mode = 3'd0;
		req.tunnel = 4'd0;
		req.address = 32'd0;
		req.prefix_len = 6'd0;
		req.nexthop = 32'd0;
		req.now = 32'd0;
		rsp.ready = 1'b0;
		calm = 1'b0;
		hold_reqs = 1'b0;
		error_count = 0;
		insert_seq = 0;
		tunnel_limit = 5'd16;
		for (int s = 0; s < NSLOT; s++) begin
			tbl_valid[s] = 1'b0;
		end
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: each mode, the /0 route, prefix saturation and ties.
		pending_reqs.push_back(make_req(prt_pkg::MODE_LOOKUP_A, 4'd0, 32'h0A00_0001, 6'd0,
			0, 0));
		pending_reqs.push_back(make_req(prt_pkg::MODE_UPDATE, 4'd0, 32'h0000_0000, 6'd0,
			32'h1, 32'h5));
		pending_reqs.push_back(make_req(prt_pkg::MODE_LOOKUP_T, 4'd0, 32'h0000_0000, 6'd0,
			0, 0));
		pending_reqs.push_back(make_req(prt_pkg::MODE_UPDATE, 4'd15, 32'hFFFF_FFFF, 6'd63,
			32'hFFFF_FFFF, 32'hFFFF_FFFF));
		pending_reqs.push_back(make_req(prt_pkg::MODE_LOOKUP_A, 4'd0, 32'hFFFF_FFFF, 6'd0,
			0, 0));
		pending_reqs.push_back(make_req(prt_pkg::MODE_UPDATE, 4'd1, 32'h0A00_0000, 6'd8,
			32'h11, 32'h1));
		pending_reqs.push_back(make_req(prt_pkg::MODE_UPDATE, 4'd2, 32'h0A00_0000, 6'd8,
			32'h22, 32'h2));
		pending_reqs.push_back(make_req(prt_pkg::MODE_UPDATE, 4'd1, 32'h0AFF_0000, 6'd8,
			32'h33, 32'h3));
		pending_reqs.push_back(make_req(prt_pkg::MODE_LOOKUP_A, 4'd0, 32'h0A01_0203, 6'd0,
			0, 0));
		pending_reqs.push_back(make_req(prt_pkg::MODE_UPDATE, 4'd1, 32'h0A00_0000, 6'd8,
			32'h11, 32'h9));
		pending_reqs.push_back(make_req(prt_pkg::MODE_UPDATE, 4'd1, 32'h0A00_0000, 6'd8,
			32'h44, 32'hA));
		pending_reqs.push_back(make_req(prt_pkg::MODE_LOOKUP_T, 4'd2, 32'h0A01_0203, 6'd0,
			0, 0));
		pending_reqs.push_back(make_req(prt_pkg::MODE_COUNT_T, 4'd1, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(prt_pkg::MODE_COUNT_A, 4'd0, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(prt_pkg::MODE_REMOVE, 4'd1, 32'h0AFF_0000, 6'd8, 0, 0));
		pending_reqs.push_back(make_req(prt_pkg::MODE_REMOVE, 4'd1, 32'h0AFF_0000, 6'd8, 0, 0));
		pending_reqs.push_back(make_req(prt_pkg::MODE_CLEAR_T, 4'd2, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(prt_pkg::MODE_COUNT_A, 4'd0, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(prt_pkg::MODE_CLEAR_A, 4'd0, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(prt_pkg::MODE_COUNT_A, 4'd0, 0, 0, 0, 0));
		wait_drained();

		// Out of range tunnels and stale entries with a lowered limit.
		pending_reqs.push_back(make_req(prt_pkg::MODE_UPDATE, 4'd3, 32'hC0A8_0000, 6'd16,
			32'h7, 32'h7));
		wait_drained();
		write_tunnels(5'd2);
		pending_reqs.push_back(make_req(prt_pkg::MODE_LOOKUP_A, 4'd0, 32'hC0A8_0101, 6'd0,
			0, 0));
		pending_reqs.push_back(make_req(prt_pkg::MODE_COUNT_A, 4'd0, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(prt_pkg::MODE_UPDATE, 4'd3, 32'h1, 6'd32, 0, 0));
		pending_reqs.push_back(make_req(prt_pkg::MODE_CLEAR_A, 4'd0, 0, 0, 0, 0));
		wait_drained();

		// Random phases over several register settings, the extremes among them.
		write_tunnels(5'd0);
		run_random(60, 2);
		write_tunnels(5'd31);
		run_random(40, 15);
		// Hold requests until every pending result has come.
		hold_reqs = 1'b1;
		wait_drained();
		hold_reqs = 1'b0;
		write_tunnels(5'd1);
		run_random(50, 1);
		write_tunnels(5'd16);
		// Fill the table to reach the full case, then continue.
		for (int i = 0; i < 70; i++) begin
			pending_reqs.push_back(make_req(prt_pkg::MODE_UPDATE, 4'($urandom_range(15, 0)),
				$urandom(), 6'($urandom_range(32, 1)), $urandom(), $urandom()));
		end
		pending_reqs.push_back(make_req(prt_pkg::MODE_COUNT_A, 4'd0, 0, 0, 0, 0));
		wait_drained();
		run_random(100, 15);
		write_tunnels(5'd7);
		run_random(80, 9);
		write_tunnels(5'd16);
		calm = 1'b1;
		run_random(80, 15);

		if (error_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	initial begin
		#3000000;
		$display("== FAIL ==");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/prt_pkg.sv
rtl/prt_if.sv
rtl/prt_ctrl.sv
rtl/prt_dp.sv
rtl/prefix_route_table.sv
rtl/prt_check.sv
tb/prefix_route_table_tb.sv
